/* hw/rtl/gclf_pkg.sv */
// Shared types, character codes and helpers for the G-code line filter.
package gclf_pkg;

  typedef logic [1:0] cfg_addr_t;

  localparam cfg_addr_t CfgBlockDelete = 2'd0;
  localparam cfg_addr_t CfgMessage     = 2'd1;
  localparam cfg_addr_t CfgUserCommand = 2'd2;

  typedef enum logic [1:0] {
    KIND_LINE_CHAR = 2'd0,
    KIND_MSG_CHAR  = 2'd1,
    KIND_END       = 2'd2,
    KIND_CANCEL    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CLASS_EMPTY    = 3'd0,
    CLASS_OVERFLOW = 3'd1,
    CLASS_SYSTEM   = 3'd2,
    CLASS_USER     = 3'd3,
    CLASS_GCODE    = 3'd4
  } line_class_e;

  typedef enum logic [1:0] {
    EOL_NONE = 2'd0,
    EOL_LF   = 2'd1,
    EOL_CR   = 2'd2
  } eol_e;

  localparam logic [7:0] ChCan       = 8'h18;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChDollar    = 8'h24;
  localparam logic [7:0] ChParOpen   = 8'h28;
  localparam logic [7:0] ChParClose  = 8'h29;
  localparam logic [7:0] ChSemicolon = 8'h3B;
  localparam logic [7:0] ChBracket   = 8'h5B;

  // Tracker value once "(MSG," has been matched.
  localparam logic [2:0] MsgTrackDone = 3'd5;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  // Expected character of the "(MSG," tag at a given tracker step.
  function automatic logic [7:0] msg_tag(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h28; // (
      3'd1:    r = 8'h4D; // M
      3'd2:    r = 8'h53; // S
      3'd3:    r = 8'h47; // G
      3'd4:    r = 8'h2C; // ,
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/gcode_line_filter.sv */
// Top level of the G-code line filter: byte-wise line cleanup and end-of-line report.
//
// Usage: feed one received byte per item on the rx channel (in_valid_i/in_ready_o,
// rx_byte_i). Each byte yields zero or one result item on the out channel
// (out_valid_o/out_ready_i): a kept line character with its column, a message
// character from a "(MSG," comment, an end of line with length, class and message
// flag, or a cancel. Other control bytes, whitespace outside $ lines and other
// comment bytes give no result. A byte accepted into the input register is
// processed from there into the result register; two register stages in all
// (input, result). Throughput: one byte per cycle unless a held result stalls
// processing; the line state update between the two registers is combinational.
// A held result stalls processing of the byte in the input register; the input
// register still takes a new byte whenever the byte it holds is processed in the
// same cycle. The configuration port (cfg_we_i, cfg_addr_i, cfg_wdata_i) writes
// one register per cycle and should be written only while the block is idle.
// Reset clears all line state, the configuration and both valid flags.
module gcode_line_filter #(
  parameter int LINE_LENGTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  gclf_pkg::cfg_addr_t cfg_addr_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          data_o,
  output logic [7:0]          position_o,
  output logic [2:0]          line_class_o,
  output logic                has_message_o
);
  import gclf_pkg::*;

  localparam int CW = $clog2(LINE_LENGTH);
  localparam logic [CW-1:0] LastCol = CW'(LINE_LENGTH - 1);

  typedef struct packed {
    logic [CW-1:0] char_count;
    logic [7:0]    first_char;
    logic          overflow;
    logic          paren;
    logic          semicolon;
    logic          del_rest;
    logic          no_caps;
    logic          keep_literal;
    logic [2:0]    msg_tracker;
    logic [CW-1:0] msg_count;
    logic          msg_seen;
  } line_t;

  logic cfg_bdel_q, cfg_message_q, cfg_user_q;

  logic       in_valid_q;
  logic [7:0] rx_byte_q;

  line_t line_q, line_d;
  eol_e  last_eol_q, last_eol_d;

  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic [7:0]  position_q, position_d;
  line_class_e class_q, class_d;
  logic        has_msg_q, has_msg_d;
  logic        res_valid;

  logic proc;

  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bdel_q    <= 1'b0;
      cfg_message_q <= 1'b0;
      cfg_user_q    <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CfgBlockDelete) cfg_bdel_q    <= cfg_wdata_i;
      if (cfg_addr_i == CfgMessage)     cfg_message_q <= cfg_wdata_i;
      if (cfg_addr_i == CfgUserCommand) cfg_user_q    <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rx_byte_q <= rx_byte_i;
    end
  end

  // line state update and result formation
  always_comb begin
    logic [7:0]  c;
    logic        flags;
    logic        drop;
    eol_e        code;
    logic [7:0]  d;
    logic [7:0]  s;

    c          = rx_byte_q;
    line_d     = line_q;
    last_eol_d = last_eol_q;
    res_valid  = 1'b0;
    kind_d     = KIND_LINE_CHAR;
    data_d     = 8'h00;
    position_d = 8'h00;
    class_d    = CLASS_EMPTY;
    has_msg_d  = 1'b0;
    flags      = line_q.overflow | line_q.paren | line_q.semicolon | line_q.del_rest;
    drop       = (line_q.no_caps ? (c < ChSpace) : (c <= ChSpace)) || flags;
    code       = (c == ChLf) ? EOL_LF : EOL_CR;
    d          = (c == ChParClose) ? 8'h00 : c;
    s          = line_q.no_caps ? c : upcase(c);

    if (proc) begin
      if (c == ChCan) begin
        line_d     = '0;
        last_eol_d = EOL_NONE;
        res_valid  = 1'b1;
        kind_d     = KIND_CANCEL;
      end else if (c == ChLf || c == ChCr) begin
        if (line_q.char_count == '0 && last_eol_q != EOL_NONE && last_eol_q != code) begin
          // second byte of a CR/LF pair
          last_eol_d = EOL_NONE;
        end else begin
          last_eol_d = code;
          res_valid  = 1'b1;
          kind_d     = KIND_END;
          position_d = 8'(line_q.char_count);
          has_msg_d  = line_q.msg_seen;
          priority if (line_q.overflow) begin
            class_d = CLASS_OVERFLOW;
          end else if (line_q.char_count == '0 && !line_q.msg_seen) begin
            class_d = CLASS_EMPTY;
          end else if (line_q.first_char == ChDollar) begin
            class_d = CLASS_SYSTEM;
          end else if (line_q.first_char == ChBracket && cfg_user_q) begin
            class_d = CLASS_USER;
          end else begin
            class_d = CLASS_GCODE;
          end
          line_d = '0;
        end
      end else if (drop) begin
        if (c >= ChSpace && line_q.paren) begin
          if (line_q.msg_tracker == MsgTrackDone) begin
            if (d == 8'h00 || line_q.msg_count < LastCol) begin
              res_valid          = 1'b1;
              kind_d             = KIND_MSG_CHAR;
              data_d             = d;
              position_d         = 8'(line_q.msg_count);
              line_d.msg_count   = line_q.msg_count + 1'b1;
            end
          end else if (line_q.msg_tracker != 3'd0 && line_q.msg_tracker < MsgTrackDone &&
                       upcase(c) == msg_tag(line_q.msg_tracker)) begin
            line_d.msg_tracker = line_q.msg_tracker + 3'd1;
          end else begin
            line_d.msg_tracker = 3'd0;
          end
          if (c == ChParClose) begin
            line_d.paren        = 1'b0;
            line_d.keep_literal = 1'b0;
            if (line_d.msg_tracker == MsgTrackDone) line_d.msg_seen = 1'b1;
          end
        end
      end else begin
        priority if (c == ChSlash) begin
          if (line_q.char_count == '0) line_d.del_rest = cfg_bdel_q;
        end else if (c == ChDollar) begin
          if (line_q.char_count == '0) begin
            line_d.no_caps      = 1'b1;
            line_d.keep_literal = 1'b1;
          end
        end else if (c == ChParOpen) begin
          if (!line_q.keep_literal) begin
            line_d.paren        = 1'b1;
            line_d.msg_tracker  = cfg_message_q ? 3'd1 : 3'd0;
            line_d.msg_count    = '0;
            line_d.keep_literal = 1'b1;
          end
        end else if (c == ChSemicolon) begin
          if (!line_q.keep_literal) begin
            line_d.semicolon    = 1'b1;
            line_d.keep_literal = 1'b1;
          end
        end else begin
        end

        if (!(line_d.paren | line_d.semicolon | line_d.del_rest)) begin
          if (line_q.char_count >= LastCol) begin
            line_d.overflow = 1'b1;
          end else begin
            // keep the character at its column
            if (line_q.char_count == '0) line_d.first_char = s;
            line_d.char_count = line_q.char_count + 1'b1;
            res_valid         = 1'b1;
            kind_d            = KIND_LINE_CHAR;
            data_d            = s;
            position_d        = 8'(line_q.char_count);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q     <= '0;
      last_eol_q <= EOL_NONE;
    end else begin
      line_q     <= line_d;
      last_eol_q <= last_eol_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_valid) begin
      kind_q     <= kind_d;
      data_q     <= data_d;
      position_q <= position_d;
      class_q    <= class_d;
      has_msg_q  <= has_msg_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign data_o        = data_q;
  assign position_o    = position_q;
  assign line_class_o  = class_q;
  assign has_message_o = has_msg_q;

  a_comment_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(line_q.paren && line_q.semicolon))
    else $error("paren and semicolon comment active together");

  a_tracker_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q.msg_tracker <= MsgTrackDone)
    else $error("message tracker out of range");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q.char_count <= LastCol)
    else $error("line count beyond buffer limit");

  a_no_caps_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q.no_caps |-> (line_q.first_char == ChDollar && line_q.char_count != '0))
    else $error("literal line without leading dollar");

endmodule
